// File: sv/token_bucket_rate_limiter_top_macros.svh
// ----------------------------------------------------------------------------
// Token bucket rate limiter assertion macros
// Shared property wrappers clocked on aclk with the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_RATE_LIMITER_TOP_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define TBRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define TBRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Check taken in the cycle after reset is sampled low
`define TBRL_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tbrl_pkg.sv
// ----------------------------------------------------------------------------
// Token bucket rate limiter package
// Widths, register map, item types and the start level table helper.
// ----------------------------------------------------------------------------
package tbrl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 48;

    localparam int LEVEL_W   = 48;
    localparam int BYTE_W    = 24;
    localparam int RATE_W    = 32;
    localparam int PCT_W     = 8;
    localparam int TICK_W    = 48;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // size * percent, and its quotient by 25
    localparam int PROD_W = BYTE_W + PCT_W;
    localparam int QUOT_W = 28;

    // floor(p / 25) == (p * ceil(2^37 / 25)) >> 37 for every 32-bit p
    localparam int          PctDiv      = 25;
    localparam int          RecipShift  = 37;
    localparam int          RECIP_W     = 33;
    localparam logic [32:0] RECIP_PCT   = 33'h1_47AE_147B;

    localparam int TAB_DEPTH = 32;
    localparam int TAB_IDX_W = 5;

    localparam logic [PCT_W-1:0] PCT_RESET = 8'd100;

    // settle count loaded on reset and on each register write while the start level pipeline catches up
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [1:0] {
        REG_RATE  = 2'd0,
        REG_SIZE  = 2'd1,
        REG_PCT   = 2'd2,
        REG_UNLIM = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_REFILL  = 2'd1,
        KIND_CONSUME = 2'd2,
        KIND_ASK     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [TICK_W-1:0]  now_ticks;
        logic [BYTE_W-1:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic               may_write;
        logic [BYTE_W-1:0]  granted;
        logic [BYTE_W-1:0]  level_bytes;
    } out_item_t;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [BYTE_W-1:0]  size;
        logic               unlimited;
        logic [LEVEL_W-1:0] start_level;
    } cfg_t;

    // floor(r * 2^k / 25), evaluated at elaboration for the remainder table
    function automatic longint unsigned frac_tab_entry(int unsigned r, int unsigned k);
        longint unsigned num;
        num = longint'(r) << k;
        return num / PctDiv;
    endfunction

endpackage

// File: sv/tbrl_cfg.sv
// ----------------------------------------------------------------------------
// Token bucket configuration registers
// APB register file plus a three-stage pipeline for the start level.
// ----------------------------------------------------------------------------
module tbrl_cfg import tbrl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg,
    output logic                  busy
);

    localparam int TabShift = FRAC_BITS - 2;

    logic [RATE_W-1:0]  rate_reg;
    logic [BYTE_W-1:0]  size_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic               unlim_reg;
    logic [1:0]         settle_cnt_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_d_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [LEVEL_W-1:0] start_reg;

    logic               wr_en;
    reg_idx_t           reg_idx;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [TAB_IDX_W-1:0]      rem;
    logic [TabShift-1:0]       frac_tab [TAB_DEPTH];
    logic [63:0]               start_full;
    logic [LEVEL_W-1:0]        start_next;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= '0;
            size_reg  <= '0;
            pct_reg   <= PCT_RESET;
            unlim_reg <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RATE:  rate_reg  <= pwdata[RATE_W-1:0];
                REG_SIZE:  size_reg  <= pwdata[BYTE_W-1:0];
                REG_PCT:   pct_reg   <= pwdata[PCT_W-1:0];
                REG_UNLIM: unlim_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RATE:  prdata = APB_DATA_W'(rate_reg);
            REG_SIZE:  prdata = APB_DATA_W'(size_reg);
            REG_PCT:   prdata = APB_DATA_W'(pct_reg);
            REG_UNLIM: prdata = APB_DATA_W'(unlim_reg);
            default:   prdata = '0;
        endcase
    end

    // Hold off items until the start level reflects the latest write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_cnt_reg <= SETTLE_CYCLES;
        end else if (wr_en) begin
            settle_cnt_reg <= SETTLE_CYCLES;
        end else if (settle_cnt_reg != 2'd0) begin
            settle_cnt_reg <= settle_cnt_reg - 2'd1;
        end
    end

    assign busy = (settle_cnt_reg != 2'd0);

    // start = floor(size * pct * 2^F / 100) = q * 2^(F-2) + floor(r * 2^(F-2) / 25)
    assign recip_prod = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP_PCT);
    assign rem = TAB_IDX_W'(prod_d_reg - PROD_W'(quot_reg) * PROD_W'(PctDiv));

    for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_frac_tab
        if (gi < PctDiv) begin : g_used
            assign frac_tab[gi] = TabShift'(frac_tab_entry(gi, TabShift));
        end else begin : g_unused
            assign frac_tab[gi] = '0;
        end
    end

    assign start_full = (64'(quot_reg) << TabShift) + 64'(frac_tab[rem]);
    assign start_next = (start_full[63:LEVEL_W] != '0) ? '1 : start_full[LEVEL_W-1:0];

    always_ff @(posedge aclk) begin
        prod_reg   <= PROD_W'(size_reg) * PROD_W'(pct_reg);
        quot_reg   <= QUOT_W'(recip_prod >> RecipShift);
        prod_d_reg <= prod_reg;
        start_reg  <= start_next;
    end

    assign cfg.rate        = rate_reg;
    assign cfg.size        = size_reg;
    assign cfg.unlimited   = unlim_reg;
    assign cfg.start_level = start_reg;

endmodule

// File: sv/tbrl_core.sv
// ----------------------------------------------------------------------------
// Token bucket core
// Holds level and last refill time, computes one result per item.
// ----------------------------------------------------------------------------
module tbrl_core import tbrl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [LEVEL_W-1:0]   level_reg;
    logic [LEVEL_W-1:0]   level_next;
    logic [TIME_BITS-1:0] last_time_reg;
    logic [TIME_BITS-1:0] last_time_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [63:0]          elapsed_ext;
    logic                 big;
    logic [63:0]          prod;
    logic [63:0]          one;
    logic [LEVEL_W-1:0]   cap;
    logic [LEVEL_W-1:0]   gain;
    logic                 refill_take;
    logic                 above_cap;
    logic [LEVEL_W:0]     refill_sum;
    logic [LEVEL_W-1:0]   refill_level;
    logic [LEVEL_W-1:0]   sub;
    logic [LEVEL_W-1:0]   consume_level;
    logic [LEVEL_W-1:0]   whole_now;
    logic [LEVEL_W-1:0]   whole_next;
    logic                 may;
    logic [BYTE_W-1:0]    granted;

    assign now_t       = TIME_BITS'(item.now_ticks);
    assign elapsed     = now_t - last_time_reg;
    assign elapsed_ext = 64'(elapsed);
    assign big         = (elapsed_ext[63:32] != '0);
    assign prod        = 64'(elapsed_ext[31:0]) * 64'(cfg.rate);
    assign one         = 64'(1) << FRAC_BITS;
    assign cap         = LEVEL_W'(cfg.size) << FRAC_BITS;

    // Skip refills worth under one byte so the fraction keeps accruing
    assign refill_take = !cfg.unlimited && (cfg.rate != '0) && (elapsed != '0)
                         && (big || (prod >= one));
    assign gain = (big || (prod > 64'(cap))) ? cap : prod[LEVEL_W-1:0];

    assign above_cap    = (level_reg > cap);
    assign refill_sum   = {1'b0, level_reg} + {1'b0, gain};
    assign refill_level = (refill_sum > {1'b0, cap}) ? cap : refill_sum[LEVEL_W-1:0];

    assign sub           = LEVEL_W'(item.amount) << FRAC_BITS;
    assign consume_level = (level_reg > sub) ? (level_reg - sub) : '0;

    assign whole_now = level_reg >> FRAC_BITS;

    always_comb begin
        level_next     = level_reg;
        last_time_next = last_time_reg;
        may            = 1'b0;
        granted        = '0;
        case (item.kind)
            KIND_START: begin
                level_next     = cfg.start_level;
                last_time_next = now_t;
            end
            KIND_REFILL: begin
                if (refill_take) begin
                    last_time_next = now_t;
                    // leave an initial burst above capacity to drain
                    if (!above_cap) begin
                        level_next = refill_level;
                    end
                end
            end
            KIND_CONSUME: begin
                if ((item.amount != '0) && !cfg.unlimited) begin
                    level_next = consume_level;
                end
            end
            KIND_ASK: begin
                if (cfg.unlimited) begin
                    may     = 1'b1;
                    granted = item.amount;
                end else if (whole_now != '0) begin
                    may     = 1'b1;
                    granted = (LEVEL_W'(item.amount) < whole_now) ? item.amount
                                                                  : whole_now[BYTE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign whole_next = level_next >> FRAC_BITS;

    assign result.may_write   = may;
    assign result.granted     = granted;
    assign result.level_bytes = (whole_next > LEVEL_W'({BYTE_W{1'b1}})) ? '1
                                                                        : whole_next[BYTE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            last_time_reg <= '0;
        end else if (fire) begin
            level_reg     <= level_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

// File: sv/token_bucket_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// Token bucket rate limiter: an item is held in the input register, then passes
// through the core into the result register. Throughput 1 item per cycle while the
// output is not stalled and no register write settles; the level update is one pass
// through the core. Reset (aresetn low, synchronous) empties level, time and pipeline;
// input stays blocked after reset or a register write while the start level settles.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_top import tbrl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    cfg_t      cfg;
    logic      cfg_busy;
    logic      advance;
    out_item_t core_result;

    assign pready = 1'b1;

    tbrl_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .busy    (cfg_busy)
    );

    tbrl_core #(
        .FRAC_BITS (FRAC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Advance when the result register is free or being drained this cycle
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !cfg_busy && (!in_valid_reg || advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

// File: sv/tbrl_checker.sv
// ----------------------------------------------------------------------------
// Token bucket rate limiter port checker
// Watches the top level ports and is bound to every instance.
// ----------------------------------------------------------------------------
`include "token_bucket_rate_limiter_top_macros.svh"

module tbrl_checker import tbrl_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item,
    input logic      psel,
    input logic      penable,
    input logic      pwrite,
    input logic      pready
);

    // stalled result transfer keeps its payload
    `TBRL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")

    // nothing is granted unless writing is allowed
    `TBRL_ASSERT_NOW(a_grant_needs_may, m_valid && !m_item.may_write, m_item.granted == '0, "grant without may_write")

    // a register write blocks input while the start level settles
    `TBRL_ASSERT_NEXT(a_cfg_blocks_input, psel && penable && pwrite && pready, !s_ready, "input open right after register write")

    // reset empties the result stage and closes the input
    `TBRL_ASSERT_RESET(a_reset_clears, !m_valid && !s_ready, "result or ready active after reset")

endmodule

bind token_bucket_rate_limiter_top tbrl_checker u_tbrl_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket rate limiter testbench
// Sends start, refill, consume and ask transfers with random gaps and output
// stalls under several register settings, predicts every result with a
// behavioral model of the fixed point bucket and checks each output transfer.
// ----------------------------------------------------------------------------
module testbench;
    import tbrl_pkg::*;

    localparam int          FRAC      = FRAC_BITS_DEF;
    localparam logic [63:0] ONE_BYTE  = 64'd1 << FRAC;
    localparam logic [63:0] LEVEL_MAX = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] BYTE_MAX  = 64'hFF_FFFF;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // register copies and bucket state of the model
    logic [RATE_W-1:0] cfg_rate  = '0;
    logic [BYTE_W-1:0] cfg_size  = '0;
    logic [PCT_W-1:0]  cfg_pct   = PCT_RESET;
    logic              cfg_unlim = 1'b0;
    logic [63:0]       credit    = '0;
    logic [TICK_W-1:0] stamp     = '0;

    in_item_t  pending_items[$];
    out_item_t due_results[$];
    int        n_pushed   = 0;
    int        n_accepted = 0;
    int        n_checked  = 0;
    int        n_err      = 0;
    int        gap_left   = 0;
    int        stall_left = 0;
    logic      calm       = 1'b0;
    logic      hold_off   = 1'b0;

    token_bucket_rate_limiter_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Apply one item to the bucket and return the result it produces
    function automatic out_item_t bucket_step(in_item_t it);
        out_item_t         r;
        logic [63:0]       cap;
        logic [63:0]       gain;
        logic [63:0]       prod;
        logic [63:0]       whole;
        logic [TICK_W-1:0] elapsed;
        logic              go;
        r   = '0;
        go  = 1'b0;
        cap = 64'(cfg_size) << FRAC;
        case (it.kind)
            KIND_START: begin
                prod   = ((64'(cfg_size) * 64'(cfg_pct)) << FRAC) / 64'd100;
                credit = (prod > LEVEL_MAX) ? LEVEL_MAX : prod;
                stamp  = it.now_ticks;
            end
            KIND_REFILL: begin
                elapsed = it.now_ticks - stamp;
                if (!cfg_unlim && cfg_rate != 0 && elapsed != 0) begin
                    if (elapsed[TICK_W-1:32] != 0) begin
                        gain = cap;
                        go   = 1'b1;
                    end else begin
                        prod = 64'(elapsed) * 64'(cfg_rate);
                        if (prod >= ONE_BYTE) begin
                            gain = (prod > cap) ? cap : prod;
                            go   = 1'b1;
                        end
                    end
                    // a level above capacity is an initial burst: leave it draining
                    if (go) begin
                        stamp = it.now_ticks;
                        if (credit <= cap) begin
                            credit = credit + gain;
                            if (credit > cap) credit = cap;
                        end
                    end
                end
            end
            KIND_CONSUME: begin
                if (it.amount != 0 && !cfg_unlim) begin
                    prod   = 64'(it.amount) << FRAC;
                    credit = (credit > prod) ? credit - prod : 64'd0;
                end
            end
            default: begin
                whole = credit >> FRAC;
                if (cfg_unlim) begin
                    r.may_write = 1'b1;
                    r.granted   = it.amount;
                end else if (whole != 0) begin
                    r.may_write = 1'b1;
                    r.granted   = (64'(it.amount) < whole) ? it.amount : whole[BYTE_W-1:0];
                end
            end
        endcase
        whole         = credit >> FRAC;
        r.level_bytes = (whole > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : whole[BYTE_W-1:0];
        return r;
    endfunction

    // Sender: hold the item until the transfer, then offer the next one or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                due_results.push_back(bucket_step(s_item));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 6) - 1;
                    s_valid  <= 1'b0;
                end else begin
                    s_item  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Receiver: random stall bursts, overridden by the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Hold the output off long enough for the block to back up its input
    initial begin
        while (n_accepted < 150) @(negedge aclk);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (80) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: may_write=%0d granted=%0d level_bytes=%0d",
                             m_item.may_write, m_item.granted, m_item.level_bytes);
            end else begin
                want = due_results.pop_front();
                n_checked++;
                if (m_item.may_write !== want.may_write || m_item.granted !== want.granted ||
                    m_item.level_bytes !== want.level_bytes) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("result %0d mismatch: expected may_write=%0d granted=%0d level_bytes=%0d",
                                 n_checked, want.may_write, want.granted, want.level_bytes);
                        $display("    got may_write=%0d granted=%0d level_bytes=%0d",
                                 m_item.may_write, m_item.granted, m_item.level_bytes);
                    end
                end
            end
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RATE: cfg_rate  = val[RATE_W-1:0];
            REG_SIZE: cfg_size  = val[BYTE_W-1:0];
            REG_PCT:  cfg_pct   = val[PCT_W-1:0];
            default:  cfg_unlim = val[0];
        endcase
    endtask

    task automatic set_regs(logic [RATE_W-1:0] rate, logic [BYTE_W-1:0] size,
                            logic [PCT_W-1:0] pct, logic unlim);
        apb_write(REG_RATE, APB_DATA_W'(rate));
        apb_write(REG_SIZE, APB_DATA_W'(size));
        apb_write(REG_PCT, APB_DATA_W'(pct));
        apb_write(REG_UNLIM, APB_DATA_W'(unlim));
    endtask

    task automatic offer(kind_t k, logic [TICK_W-1:0] t, logic [BYTE_W-1:0] a);
        in_item_t it;
        it.kind      = k;
        it.now_ticks = t;
        it.amount    = a;
        pending_items.push_back(it);
        n_pushed++;
    endtask

    // Wait until every transfer has come back, then let the pipeline settle
    task automatic drain();
        while (n_checked != n_pushed) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_amount();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return BYTE_W'($urandom_range(0, cfg_size / 4 + 8));
        if (roll < 7) return BYTE_W'($urandom_range(0, 255));
        if (roll < 8) return '0;
        return BYTE_W'($urandom);
    endfunction

    // Mostly a start followed by advancing time, with jumps, wraps and rewinds
    task automatic run_phase(int n);
        logic [TICK_W-1:0] t;
        kind_t             k;
        int                roll;
        t = TICK_W'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) offer(KIND_START, t, rand_amount());
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)       k = KIND_START;
            else if (roll < 45) k = KIND_REFILL;
            else if (roll < 70) k = KIND_CONSUME;
            else                k = KIND_ASK;
            roll = $urandom_range(0, 99);
            if (roll < 55)      t = t + TICK_W'($urandom_range(0, 64));
            else if (roll < 70) t = t + TICK_W'($urandom_range(0, 1 << 20));
            else if (roll < 80) t = t + TICK_W'($urandom);
            else if (roll < 87) t = t + TICK_W'({$urandom, $urandom});
            else if (roll < 93) t = t - TICK_W'($urandom_range(1, 1000));
            else                t = TICK_W'({$urandom, $urandom});
            if ((k == KIND_CONSUME || k == KIND_ASK) && $urandom_range(0, 1) == 0)
                offer(k, TICK_W'({$urandom, $urandom}), rand_amount());
            else
                offer(k, t, rand_amount());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // half a byte per tick, 1000 byte bucket
        set_regs(32'h0000_8000, 24'd1000, 8'd100, 1'b0);
        offer(KIND_START, 48'd0, 24'd0);
        offer(KIND_ASK, 48'd0, 24'd0);
        offer(KIND_ASK, 48'd0, 24'hFF_FFFF);
        offer(KIND_CONSUME, 48'd0, 24'd0);
        offer(KIND_CONSUME, 48'd0, 24'd300);
        offer(KIND_REFILL, 48'd1, 24'd0);                 // gain under one byte
        offer(KIND_REFILL, 48'd2, 24'd0);
        offer(KIND_REFILL, 48'd2, 24'd0);                 // no time passed
        offer(KIND_REFILL, 48'h1_0000_0002, 24'hFF_FFFF); // very long wait
        offer(KIND_CONSUME, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
        offer(KIND_ASK, 48'd0, 24'd5);                    // empty bucket
        offer(KIND_START, 48'hFFFF_FFFF_FFFC, 24'd0);
        offer(KIND_CONSUME, 48'd0, 24'd600);
        offer(KIND_REFILL, 48'd4, 24'd0);                 // counter wrap
        offer(KIND_REFILL, 48'd1, 24'd0);                 // time runs backwards
        offer(KIND_ASK, 48'hAAAA_AAAA_AAAA, 24'hAA_AAAA);
        drain();

        // start above capacity: burst drains before any refill
        apb_write(REG_PCT, 32'd255);
        offer(KIND_START, 48'd100, 24'd0);
        offer(KIND_REFILL, 48'd200, 24'd0);
        offer(KIND_ASK, 48'd0, 24'd2000);
        offer(KIND_CONSUME, 48'h5555_5555_5555, 24'd2000);
        offer(KIND_REFILL, 48'd1000, 24'h55_5555);
        drain();

        apb_write(REG_UNLIM, 32'd1);
        offer(KIND_REFILL, 48'd5000, 24'd0);
        offer(KIND_CONSUME, 48'd0, 24'd100);
        offer(KIND_ASK, 48'd0, 24'hFF_FFFF);
        offer(KIND_START, 48'd0, 24'd0);
        drain();

        // shrinking the bucket leaves the current level alone
        apb_write(REG_SIZE, 32'd10);
        apb_write(REG_UNLIM, 32'd0);
        offer(KIND_ASK, 48'd0, 24'd3000);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_regs(32'hFFFF_FFFF, 24'hFF_FFFF, 8'd255, 1'b0);
                1: set_regs(32'd0, 24'd0, 8'd0, 1'b0);
                2: set_regs($urandom, BYTE_W'($urandom_range(1, 5000)),
                            PCT_W'($urandom_range(0, 255)), 1'b1);
                default: set_regs(($urandom_range(0, 1) != 0) ?
                                      RATE_W'($urandom_range(1, 32'h3_0000)) : $urandom,
                                  ($urandom_range(0, 1) != 0) ?
                                      BYTE_W'($urandom_range(1, 4000)) : BYTE_W'($urandom),
                                  PCT_W'($urandom_range(0, 255)),
                                  $urandom_range(0, 5) == 0);
            endcase
            calm <= (p == 7) || ($urandom_range(0, 3) == 0);
            run_phase(88);
            drain();
        end

        if (n_err == 0 && due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
